// File: sv/occupancy_grid_ray_tracer_top_assert.svh
`ifndef OCCUPANCY_GRID_RAY_TRACER_TOP_ASSERT_SVH
`define OCCUPANCY_GRID_RAY_TRACER_TOP_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted.
`define OGRT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true.
`define OGRT_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `OGRT_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

// File: sv/ogrt_pkg.sv
package ogrt_pkg;

  localparam int unsigned DefMaxColumns = 256;
  localparam int unsigned DefMaxRows    = 256;

  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 9;
  localparam int unsigned CoordW    = 8;
  localparam int unsigned SizeW     = 9;
  localparam int unsigned CellW     = 2;
  localparam int unsigned OccW      = 17;
  localparam int unsigned RayW      = 32;
  localparam int unsigned ErrW      = 11;

  localparam logic [SizeW-1:0]  ResetGridColumns  = 9'd256;
  localparam logic [SizeW-1:0]  ResetGridRows     = 9'd256;
  localparam logic [CoordW-1:0] ResetOriginColumn = 8'd128;
  localparam logic [CoordW-1:0] ResetOriginRow    = 8'd128;

  typedef enum logic [CellW-1:0] {
    CELL_UNKNOWN  = 2'd0,
    CELL_FREE     = 2'd1,
    CELL_OCCUPIED = 2'd2
  } cell_e;

  typedef enum logic [1:0] {
    ACT_TRACE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_GRID_COLUMNS  = 2'd0,
    CFG_GRID_ROWS     = 2'd1,
    CFG_ORIGIN_COLUMN = 2'd2,
    CFG_ORIGIN_ROW    = 2'd3
  } cfg_index_e;

endpackage

// File: sv/occupancy_grid_ray_tracer_top.sv
// Occupancy grid ray tracer.
// Command channel: a request (action_i, target_column_i, target_row_i) is
// taken at a clock edge where start is high and busy is low. Each request
// gives one result, shown for a single cycle with result_valid_o high; the
// receiver cannot stall it, so the block never waits on the output side.
// Config port: cfg_we_i writes cfg_wdata_i into register cfg_index_i at
// once; write it only while the block is idle.
// Path from the accepting edge to the result strobe:
//   trace in range : ST_WALK from origin to target, then ST_DRAIN; the walk
//                    does one cell read-modify-write per cycle on the
//                    single grid RAM (read one cell, write the previous).
//   read, or trace out of range with target in grid : ST_LOOK, ST_SAMPLE.
//   target out of range : the result is registered straight from idle.
//   clear : ST_CLEAR sweeps all MAX_COLUMNS*MAX_ROWS entries, one per cycle.
// A new request may be taken in the cycle the result is shown.
// Reset: control and config registers reset; the grid RAM is swept to
// unknown, all MAX_COLUMNS*MAX_ROWS entries (65536 by default), with busy
// high; config writes are taken during the sweep. No result is given for it.
`include "occupancy_grid_ray_tracer_top_assert.svh"

module occupancy_grid_ray_tracer_top #(
  parameter int unsigned MAX_COLUMNS = ogrt_pkg::DefMaxColumns,
  parameter int unsigned MAX_ROWS    = ogrt_pkg::DefMaxRows
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     action_i,
  input  logic [ogrt_pkg::CoordW-1:0]    target_column_i,
  input  logic [ogrt_pkg::CoordW-1:0]    target_row_i,
  input  logic                           cfg_we_i,
  input  logic [ogrt_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [ogrt_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output logic                           result_valid_o,
  output logic [ogrt_pkg::CellW-1:0]     cell_state_o,
  output logic                           out_of_range_o,
  output logic [ogrt_pkg::OccW-1:0]      occupied_total_o,
  output logic [ogrt_pkg::RayW-1:0]      ray_total_o
);

  import ogrt_pkg::*;

  localparam int unsigned Depth = MAX_COLUMNS * MAX_ROWS;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_WALK   = 6'b000010,
    ST_DRAIN  = 6'b000100,
    ST_LOOK   = 6'b001000,
    ST_SAMPLE = 6'b010000,
    ST_CLEAR  = 6'b100000
  } state_e;

  // config
  logic [SizeW-1:0]  grid_columns_q, grid_rows_q;
  logic [CoordW-1:0] origin_column_q, origin_row_q;

  // control
  state_e           state_q, state_d;
  logic             clr_report_q, clr_report_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic             wr_valid_q, wr_valid_d;
  logic             wr_end_q, wr_end_d;
  logic             res_valid_q, res_valid_d;
  logic [OccW-1:0]  occ_q, occ_d;
  logic [RayW-1:0]  ray_q, ray_d;

  // payload
  logic [CoordW-1:0] c_q, c_d, r_q, r_d;
  logic [CoordW-1:0] tc_q, tc_d, tr_q, tr_d;
  logic [CoordW-1:0] dc_q, dc_d, dr_q, dr_d;
  logic              sc_q, sc_d, sr_q, sr_d;   // 1: step toward lower index
  logic [ErrW-1:0]   err_q, err_d;
  logic [AddrW-1:0]  wr_addr_q, wr_addr_d;
  logic              flag_q, flag_d;
  logic [CellW-1:0]  res_cell_q, res_cell_d;
  logic              res_flag_q, res_flag_d;

  // RAM
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr, cell_addr;
  logic [CellW-1:0] ram_wdata, ram_rdata;

  function automatic logic in_grid(logic [CoordW-1:0] c, logic [CoordW-1:0] r,
                                   logic [SizeW-1:0] cols, logic [SizeW-1:0] rows);
    return ({1'b0, c} < cols) && (32'(c) < MAX_COLUMNS) &&
           ({1'b0, r} < rows) && (32'(r) < MAX_ROWS);
  endfunction

  logic                target_ok, origin_ok;
  logic signed [11:0]  e2;
  logic                step_c, step_r, at_end, rd_occ;
  logic [CoordW-1:0]   dc_init, dr_init;

  assign target_ok = in_grid(target_column_i, target_row_i, grid_columns_q, grid_rows_q);
  assign origin_ok = in_grid(origin_column_q, origin_row_q, grid_columns_q, grid_rows_q);

  assign dc_init = (target_column_i > origin_column_q) ? target_column_i - origin_column_q
                                                       : origin_column_q - target_column_i;
  assign dr_init = (target_row_i > origin_row_q) ? target_row_i - origin_row_q
                                                 : origin_row_q - target_row_i;

  assign e2     = $signed({err_q[ErrW-1], err_q}) <<< 1;
  assign step_c = e2 > -$signed({4'b0, dr_q});
  assign step_r = e2 < $signed({4'b0, dc_q});
  assign at_end = (c_q == tc_q) && (r_q == tr_q);
  assign rd_occ = (ram_rdata == CELL_OCCUPIED);

  assign cell_addr = AddrW'(32'(r_q) * MAX_COLUMNS + 32'(c_q));

  // Write side: the clearing sweep, or the write-back of the cell read last cycle.
  always_comb begin
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = CELL_UNKNOWN;
    end else begin
      ram_we    = wr_valid_q && !rd_occ;
      ram_waddr = wr_addr_q;
      ram_wdata = wr_end_q ? CELL_OCCUPIED : CELL_FREE;
    end
  end

  ogrt_ram #(
    .WIDTH (CellW),
    .DEPTH (Depth)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (cell_addr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    clr_report_d = clr_report_q;
    clr_d        = clr_q;
    wr_valid_d   = 1'b0;
    wr_end_d     = 1'b0;
    wr_addr_d    = cell_addr;
    res_valid_d  = 1'b0;
    res_cell_d   = res_cell_q;
    res_flag_d   = res_flag_q;
    occ_d        = occ_q;
    ray_d        = ray_q;
    c_d          = c_q;
    r_d          = r_q;
    tc_d         = tc_q;
    tr_d         = tr_q;
    dc_d         = dc_q;
    dr_d         = dr_q;
    sc_d         = sc_q;
    sr_d         = sr_q;
    err_d        = err_q;
    flag_d       = flag_q;

    // endpoint write-back lands here
    if (wr_valid_q && wr_end_q && !rd_occ && (occ_q != '1)) begin
      occ_d = occ_q + OccW'(1);
    end

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          tc_d  = target_column_i;
          tr_d  = target_row_i;
          c_d   = target_column_i;
          r_d   = target_row_i;
          case (action_i)
            ACT_CLEAR: begin
              clr_d        = '0;
              clr_report_d = 1'b1;
              state_d      = ST_CLEAR;
            end
            ACT_TRACE: begin
              if (target_ok && origin_ok) begin
                c_d     = origin_column_q;
                r_d     = origin_row_q;
                dc_d    = dc_init;
                dr_d    = dr_init;
                sc_d    = !(origin_column_q < target_column_i);
                sr_d    = !(origin_row_q < target_row_i);
                err_d   = ErrW'(dc_init) - ErrW'(dr_init);
                state_d = ST_WALK;
              end else if (target_ok) begin
                flag_d  = 1'b1;
                state_d = ST_LOOK;
              end else begin
                res_valid_d = 1'b1;
                res_cell_d  = CELL_UNKNOWN;
                res_flag_d  = 1'b1;
              end
            end
            default: begin
              // read; the unused code behaves as one
              if (target_ok) begin
                flag_d  = 1'b0;
                state_d = ST_LOOK;
              end else begin
                res_valid_d = 1'b1;
                res_cell_d  = CELL_UNKNOWN;
                res_flag_d  = 1'b1;
              end
            end
          endcase
        end
      end
      ST_WALK: begin
        // read this cell now, write it back next cycle
        wr_valid_d = 1'b1;
        if (at_end) begin
          wr_end_d = 1'b1;
          state_d  = ST_DRAIN;
        end else begin
          err_d = err_q - (step_c ? ErrW'(dr_q) : '0) + (step_r ? ErrW'(dc_q) : '0);
          if (step_c) c_d = sc_q ? c_q - 8'd1 : c_q + 8'd1;
          if (step_r) r_d = sr_q ? r_q - 8'd1 : r_q + 8'd1;
        end
      end
      ST_DRAIN: begin
        if (ray_q != '1) ray_d = ray_q + RayW'(1);
        res_valid_d = 1'b1;
        res_cell_d  = CELL_OCCUPIED;
        res_flag_d  = 1'b0;
        state_d     = ST_IDLE;
      end
      ST_LOOK: begin
        state_d = ST_SAMPLE;
      end
      ST_SAMPLE: begin
        res_valid_d = 1'b1;
        res_cell_d  = ram_rdata;
        res_flag_d  = flag_q;
        state_d     = ST_IDLE;
      end
      ST_CLEAR: begin
        clr_d = clr_q + AddrW'(1);
        if (clr_q == LastAddr) begin
          occ_d        = '0;
          ray_d        = '0;
          res_valid_d  = clr_report_q;
          res_cell_d   = CELL_UNKNOWN;
          res_flag_d   = 1'b0;
          clr_report_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_CLEAR;
      clr_report_q    <= 1'b0;
      clr_q           <= '0;
      wr_valid_q      <= 1'b0;
      wr_end_q        <= 1'b0;
      res_valid_q     <= 1'b0;
      occ_q           <= '0;
      ray_q           <= '0;
      grid_columns_q  <= ResetGridColumns;
      grid_rows_q     <= ResetGridRows;
      origin_column_q <= ResetOriginColumn;
      origin_row_q    <= ResetOriginRow;
    end else begin
      state_q      <= state_d;
      clr_report_q <= clr_report_d;
      clr_q        <= clr_d;
      wr_valid_q   <= wr_valid_d;
      wr_end_q     <= wr_end_d;
      res_valid_q  <= res_valid_d;
      occ_q        <= occ_d;
      ray_q        <= ray_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_GRID_COLUMNS:  grid_columns_q  <= cfg_wdata_i;
          CFG_GRID_ROWS:     grid_rows_q     <= cfg_wdata_i;
          CFG_ORIGIN_COLUMN: origin_column_q <= cfg_wdata_i[CoordW-1:0];
          CFG_ORIGIN_ROW:    origin_row_q    <= cfg_wdata_i[CoordW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    c_q        <= c_d;
    r_q        <= r_d;
    tc_q       <= tc_d;
    tr_q       <= tr_d;
    dc_q       <= dc_d;
    dr_q       <= dr_d;
    sc_q       <= sc_d;
    sr_q       <= sr_d;
    err_q      <= err_d;
    wr_addr_q  <= wr_addr_d;
    flag_q     <= flag_d;
    res_cell_q <= res_cell_d;
    res_flag_q <= res_flag_d;
  end

  assign busy             = (state_q != ST_IDLE);
  assign result_valid_o   = res_valid_q;
  assign cell_state_o     = res_cell_q;
  assign out_of_range_o   = res_flag_q;
  assign occupied_total_o = occ_q;
  assign ray_total_o      = ray_q;

  // A result is only raised on the way back to idle.
  `OGRT_ASSERT(a_result_in_idle, clk_i, rst_ni, res_valid_q |-> (state_q == ST_IDLE),
               "result strobe outside idle")
  // The sweep owns the write port; no write-back may be pending.
  `OGRT_ASSERT_NEVER(a_no_wb_in_clear, clk_i, rst_ni, (state_q == ST_CLEAR) && wr_valid_q,
                     "write-back pending during clear")
  // Draining always retires the endpoint.
  `OGRT_ASSERT(a_drain_end, clk_i, rst_ni, (state_q == ST_DRAIN) |-> (wr_valid_q && wr_end_q),
               "drain without endpoint write-back")
  // Occupied count only steps by one or clears.
  `OGRT_ASSERT(a_occ_step, clk_i, rst_ni,
               (occ_q != $past(occ_q)) |-> ((occ_q == OccW'($past(occ_q) + OccW'(1))) ||
                                            (occ_q == '0)),
               "occupied count jumped")

endmodule

// File: sv/ogrt_ram.sv
module ogrt_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
